### hdl/assert_macros.svh
// Assertion macros of the look-at view matrix RTL, used by lav_back.
// Depends on nothing; a synthesis run defines SYNTHESIS and the macros vanish.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define LAV_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication check.
`define LAV_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define LAV_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define LAV_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

### hdl/lav_pkg.sv
// Types, constants and small helpers of the look-at view matrix block.
// Used by lav_front, lav_back and look_at_view_matrix_top; depends on nothing.
package lav_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic signed [32:0] diff_t;

	// Request: one camera item.
	typedef struct packed {
		word_t eye_x;
		word_t eye_y;
		word_t eye_z;
		word_t look_x;
		word_t look_y;
		word_t look_z;
		word_t upward_x;
		word_t upward_y;
		word_t upward_z;
	} req_t;

	// Result: one matrix column.
	typedef struct packed {
		logic [1:0] column_index;
		word_t      row0_value;
		word_t      row1_value;
		word_t      row2_value;
		word_t      row3_value;
		logic       last_column;
		logic       degenerate;
	} rsp_t;

	// Classified job held in the queue between front and back.
	typedef struct packed {
		word_t [2:0] eye;
		word_t [2:0] up;
		diff_t [2:0] dif;
		logic        dzero;
	} job_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic valid;
		job_t job;
	} q_head_t;

	localparam int MagW = 50;   // magnitude of an unnormalized vector component
	localparam int AccW = 66;   // sum of three 64-bit products
	localparam int LenW = 31;   // integer square root of the squared length
	localparam int QW   = 18;   // quotient bits of a unit component
	localparam int NumW = 47;   // dividend of a unit component
	localparam int NormTop = 30;
	localparam int NormBot = 29;

	localparam word_t      Q_ONE    = 32'sd65536;
	localparam logic [1:0] COL_LAST = 2'd3;

	// Cyclic successor and predecessor of a vector index.
	function automatic logic [1:0] idx_next(input logic [1:0] k);
		case (k)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] idx_prev(input logic [1:0] k);
		case (k)
			2'd0:    return 2'd2;
			2'd1:    return 2'd0;
			default: return 2'd1;
		endcase
	endfunction

endpackage

### hdl/lav_front.sv
// Front end: takes camera requests, forms eye - target, flags a zero view
// direction and queues the job. Depends on lav_pkg.
module lav_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  lav_pkg::req_t    req,
	output lav_pkg::q_head_t head,
	input  logic             pop
);
	import lav_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	job_t            job_mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	job_t            new_job;
	logic            push;

	// Classify the request: view direction and its zero test.
	always_comb begin
		new_job.eye[0] = req.eye_x;
		new_job.eye[1] = req.eye_y;
		new_job.eye[2] = req.eye_z;
		new_job.up[0]  = req.upward_x;
		new_job.up[1]  = req.upward_y;
		new_job.up[2]  = req.upward_z;
		new_job.dif[0] = 33'(req.eye_x) - 33'(req.look_x);
		new_job.dif[1] = 33'(req.eye_y) - 33'(req.look_y);
		new_job.dif[2] = 33'(req.eye_z) - 33'(req.look_z);
		new_job.dzero  = (new_job.dif[0] == '0) && (new_job.dif[1] == '0) &&
			(new_job.dif[2] == '0);
	end

	assign busy = (cnt_q == CntFull);
	assign push = start && !busy;

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			job_mem[wr_ptr_q] <= new_job;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.job   = job_mem[rd_ptr_q];

endmodule

### hdl/lav_back.sv
// Back end: normalizes both axes with a shared multiplier, an iterative square
// root and an iterative divider, then emits four columns. Depends on lav_pkg.
`include "assert_macros.svh"
module lav_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lav_pkg::q_head_t head,
	output logic             pop,
	output logic             strobe,
	output lav_pkg::rsp_t    rsp
);
	import lav_pkg::*;

	typedef enum logic [10:0] {
		ST_LOAD  = 11'b00000000001,
		ST_CMAX  = 11'b00000000010,
		ST_NORM  = 11'b00000000100,
		ST_SQ    = 11'b00000001000,
		ST_SQRT  = 11'b00000010000,
		ST_DIVI  = 11'b00000100000,
		ST_DIV   = 11'b00001000000,
		ST_CROSS = 11'b00010000000,
		ST_YCALC = 11'b00100000000,
		ST_TCALC = 11'b01000000000,
		ST_EMIT  = 11'b10000000000
	} state_t;

	state_t                  state_q;
	logic                    pass_q;
	logic [1:0]              k_q, col_q;
	logic [2:0]              j_q;
	logic [4:0]              cnt_q;
	word_t                   eye_q [3];
	word_t                   up_q [3];
	word_t                   ax_x_q [3];
	word_t                   ax_y_q [3];
	word_t                   ax_z_q [3];
	word_t                   tr_q [3];
	logic                    sgn_q [3];
	logic [MagW-1:0]         mag_q [3];
	logic [MagW-1:0]         mx_q;
	logic signed [AccW-1:0]  acc_q;
	logic signed [63:0]      prod_s1;
	logic                    pneg_s1, pv_s1;
	logic [63:0]             n_q, res_q, bit_q;
	logic [LenW-1:0]         len_q, rem_q;
	logic [QW-1:0]           lo_q, quo_q;
	logic                    degen_q, strobe_q;
	rsp_t                    rsp_q;

	// Multiply-accumulate operand selection.
	logic [2:0]         nterms;
	logic [1:0]         jj, k1, k2;
	word_t              mac_a, mac_b;
	logic               mac_neg, mac_on, issue, consume;

	always_comb begin
		jj      = (j_q[1:0] == 2'd3) ? 2'd0 : j_q[1:0];
		k1      = idx_next(k_q);
		k2      = idx_prev(k_q);
		nterms  = 3'd3;
		mac_a   = '0;
		mac_b   = '0;
		mac_neg = 1'b0;
		mac_on  = 1'b1;
		case (state_q)
			ST_SQ: begin
				mac_a = {2'b00, mag_q[jj][NormTop-1:0]};
				mac_b = {2'b00, mag_q[jj][NormTop-1:0]};
			end
			ST_CROSS: begin
				nterms  = 3'd2;
				mac_a   = (j_q == 3'd0) ? up_q[k1] : up_q[k2];
				mac_b   = (j_q == 3'd0) ? ax_z_q[k2] : ax_z_q[k1];
				mac_neg = (j_q != 3'd0);
			end
			ST_YCALC: begin
				nterms  = 3'd2;
				mac_a   = (j_q == 3'd0) ? ax_z_q[k1] : ax_z_q[k2];
				mac_b   = (j_q == 3'd0) ? ax_x_q[k2] : ax_x_q[k1];
				mac_neg = (j_q != 3'd0);
			end
			ST_TCALC: begin
				mac_a   = eye_q[jj];
				mac_b   = (k_q == 2'd0) ? ax_x_q[jj] :
					(k_q == 2'd1) ? ax_y_q[jj] : ax_z_q[jj];
				mac_neg = 1'b1;
			end
			default: mac_on = 1'b0;
		endcase
		issue   = mac_on && (j_q < nterms);
		consume = mac_on && (j_q == nterms + 3'd1);
	end

	// Accumulator results: magnitude, rounding and saturation.
	logic signed [AccW-1:0] acc_abs, rsum, rnd;
	logic                   rnd_fits;
	word_t                  rnd_sat;

	always_comb begin
		acc_abs  = acc_q[AccW-1] ? -acc_q : acc_q;
		rsum     = acc_q + AccW'(32768);
		rnd      = rsum >>> 16;
		rnd_fits = (&rnd[AccW-1:31]) || !(|rnd[AccW-1:31]);
		if (rnd_fits) begin
			rnd_sat = rnd[31:0];
		end else if (rnd[AccW-1]) begin
			rnd_sat = 32'sh8000_0000;
		end else begin
			rnd_sat = 32'sh7fff_ffff;
		end
	end

	// Largest magnitude and load-time magnitudes.
	logic [MagW-1:0] m01, mxc;
	logic [32:0]     dmag [3];

	always_comb begin
		m01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
		mxc = (m01 > mag_q[2]) ? m01 : mag_q[2];
		for (int i = 0; i < 3; i++) begin
			dmag[i] = head.job.dif[i][32] ? 33'(-head.job.dif[i]) : 33'(head.job.dif[i]);
		end
	end

	// One square root step.
	logic [63:0] sq_trial, res_nx;
	logic        sq_take;

	always_comb begin
		sq_trial = res_q + bit_q;
		sq_take  = (n_q >= sq_trial);
		res_nx   = sq_take ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	end

	// One divider step and the signed unit component.
	logic [NumW-1:0] num;
	logic [LenW:0]   dv_trial, dv_diff;
	logic            dv_ge;
	logic [QW-1:0]   quo_nx;
	word_t           qv, axv;

	always_comb begin
		num      = NumW'({mag_q[k_q][NormTop-1:0], 16'h0000}) + NumW'(len_q >> 1);
		dv_trial = {rem_q, lo_q[QW-1]};
		dv_diff  = dv_trial - {1'b0, len_q};
		dv_ge    = (dv_trial >= {1'b0, len_q});
		quo_nx   = {quo_q[QW-2:0], dv_ge};
		qv       = word_t'({{(32-QW){1'b0}}, quo_nx});
		axv      = sgn_q[k_q] ? -qv : qv;
	end

	assign pop = (state_q == ST_LOAD) && head.valid;

	// Shared multiplier stage and accumulator.
	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= 64'(mac_a) * 64'(mac_b);
			pneg_s1 <= mac_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			pv_s1 <= issue;
			if (consume) begin
				acc_q <= '0;
			end else if (pv_s1) begin
				acc_q <= pneg_s1 ? acc_q - AccW'(prod_s1) : acc_q + AccW'(prod_s1);
			end
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			pass_q   <= 1'b0;
			k_q      <= '0;
			j_q      <= '0;
			cnt_q    <= '0;
			col_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (mac_on) begin
				j_q <= consume ? 3'd0 : j_q + 3'd1;
			end
			case (state_q)
				ST_LOAD: begin
					if (head.valid) begin
						pass_q  <= 1'b0;
						k_q     <= '0;
						j_q     <= '0;
						col_q   <= '0;
						state_q <= head.job.dzero ? ST_EMIT : ST_CMAX;
					end
				end
				ST_CMAX: state_q <= (mxc == '0) ? ST_EMIT : ST_NORM;
				ST_NORM: begin
					if (mx_q[MagW-1:NormTop] == '0 && mx_q[NormBot]) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (consume) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						k_q     <= '0;
						state_q <= ST_DIVI;
					end
				end
				ST_DIVI: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QW - 1)) begin
						if (k_q != 2'd2) begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_DIVI;
						end else begin
							k_q     <= '0;
							state_q <= pass_q ? ST_YCALC : ST_CROSS;
						end
					end
				end
				ST_CROSS, ST_YCALC, ST_TCALC: begin
					if (consume) begin
						if (k_q != 2'd2) begin
							k_q <= k_q + 2'd1;
						end else begin
							k_q <= '0;
							case (state_q)
								ST_CROSS: begin
									pass_q  <= 1'b1;
									state_q <= ST_CMAX;
								end
								ST_YCALC: state_q <= ST_TCALC;
								default: begin
									col_q   <= '0;
									state_q <= ST_EMIT;
								end
							endcase
						end
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					col_q    <= col_q + 2'd1;
					if (col_q == COL_LAST) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				degen_q <= head.job.dzero;
				for (int i = 0; i < 3; i++) begin
					eye_q[i] <= head.job.eye[i];
					up_q[i]  <= head.job.up[i];
					sgn_q[i] <= head.job.dif[i][32];
					mag_q[i] <= MagW'(dmag[i]);
				end
			end
			ST_CMAX: begin
				mx_q <= mxc;
				if (mxc == '0) begin
					degen_q <= 1'b1;
				end
			end
			ST_NORM: begin
				if (mx_q[MagW-1:NormTop] != '0) begin
					mx_q <= mx_q >> 1;
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end else if (!mx_q[NormBot]) begin
					mx_q <= mx_q << 1;
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
			end
			ST_SQ: begin
				if (consume) begin
					n_q   <= acc_q[63:0];
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end
			end
			ST_SQRT: begin
				if (sq_take) begin
					n_q <= n_q - sq_trial;
				end
				res_q <= res_nx;
				bit_q <= bit_q >> 2;
				if (cnt_q == 5'd31) begin
					len_q <= res_nx[LenW-1:0];
				end
			end
			ST_DIVI: begin
				rem_q <= LenW'(num[NumW-1:QW]);
				lo_q  <= num[QW-1:0];
				quo_q <= '0;
			end
			ST_DIV: begin
				rem_q <= dv_ge ? dv_diff[LenW-1:0] : dv_trial[LenW-1:0];
				lo_q  <= lo_q << 1;
				quo_q <= quo_nx;
				if (cnt_q == 5'(QW - 1)) begin
					if (pass_q) begin
						ax_x_q[k_q] <= axv;
					end else begin
						ax_z_q[k_q] <= axv;
					end
				end
			end
			ST_CROSS: begin
				if (consume) begin
					sgn_q[k_q] <= acc_q[AccW-1];
					mag_q[k_q] <= acc_abs[MagW-1:0];
				end
			end
			ST_YCALC: begin
				if (consume) begin
					ax_y_q[k_q] <= rnd[31:0];
				end
			end
			ST_TCALC: begin
				if (consume) begin
					tr_q[k_q] <= rnd_sat;
				end
			end
			ST_EMIT: begin
				rsp_q.column_index <= col_q;
				rsp_q.last_column  <= (col_q == COL_LAST);
				rsp_q.degenerate   <= degen_q;
				if (degen_q) begin
					rsp_q.row0_value <= '0;
					rsp_q.row1_value <= '0;
					rsp_q.row2_value <= '0;
					rsp_q.row3_value <= '0;
				end else begin
					case (col_q)
						2'd0: begin
							rsp_q.row0_value <= ax_x_q[0];
							rsp_q.row1_value <= ax_y_q[0];
							rsp_q.row2_value <= ax_z_q[0];
							rsp_q.row3_value <= '0;
						end
						2'd1: begin
							rsp_q.row0_value <= ax_x_q[1];
							rsp_q.row1_value <= ax_y_q[1];
							rsp_q.row2_value <= ax_z_q[1];
							rsp_q.row3_value <= '0;
						end
						2'd2: begin
							rsp_q.row0_value <= ax_x_q[2];
							rsp_q.row1_value <= ax_y_q[2];
							rsp_q.row2_value <= ax_z_q[2];
							rsp_q.row3_value <= '0;
						end
						default: begin
							rsp_q.row0_value <= tr_q[0];
							rsp_q.row1_value <= tr_q[1];
							rsp_q.row2_value <= tr_q[2];
							rsp_q.row3_value <= Q_ONE;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	// Columns of one matrix come back to back, in order, with one flag value.
	`LAV_ASSERT_NXT(a_cols_run, clk, arst_n, strobe_q && !rsp_q.last_column, strobe_q && (rsp_q.column_index == $past(rsp_q.column_index) + 2'd1))
	`LAV_ASSERT_IMP(a_last_col, clk, arst_n, strobe_q, rsp_q.last_column == (rsp_q.column_index == COL_LAST))
	`LAV_ASSERT_IMP(a_degen_zero, clk, arst_n, strobe_q && rsp_q.degenerate, (rsp_q.row0_value == '0) && (rsp_q.row3_value == '0))
	`LAV_ASSERT_IMP(a_degen_same, clk, arst_n, strobe_q && (rsp_q.column_index != 2'd0), $past(strobe_q) && (rsp_q.degenerate == $past(rsp_q.degenerate)))

endmodule

### hdl/look_at_view_matrix_top.sv
// Top level of the look-at view matrix block: front end with job queue and
// the iterative back end. Depends on lav_pkg, lav_front and lav_back.
//
//   channel   handshake          payload          direction
//   request   start / busy       req (req_t)      in
//   result    strobe             rsp (rsp_t)      out
//
// A request is taken at a clock edge with start high and busy low; busy is
// high only while the job queue (QUEUE_DEPTH entries) is full.
// A normal camera runs through the back end's shift normalizer, 32-step square
// root and 18-step divider: normalizer and root once per axis, the divider once
// per axis component; a zero view direction goes straight to the column output.
// Each matrix leaves as four column results on consecutive cycles; the
// receiver cannot stall. Reset clears the queue and the sequencer.
module look_at_view_matrix_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lav_pkg::req_t req,
	output logic          strobe,
	output lav_pkg::rsp_t rsp
);
	import lav_pkg::*;

	q_head_t head;
	logic    pop;

	lav_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.head  (head),
		.pop   (pop)
	);

	lav_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.strobe(strobe),
		.rsp   (rsp)
	);

endmodule

### tb/sv/tb_look_at_view_matrix_top.sv
// Self-checking testbench of look_at_view_matrix_top: directed and random camera requests,
// view matrix predicted in Q16.16 and compared column by column. Depends on lav_pkg.
module tb_look_at_view_matrix_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lav_pkg::*;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  strobe;
	rsp_t  rsp;

	req_t  pending_reqs[$];
	rsp_t  expected_columns[$];
	int    mismatch_count;
	int    send_idle_pct;
	int    cycle_count;
	bit    hold_send;
	bit    took_req;

	look_at_view_matrix_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .strobe(strobe), .rsp(rsp)
	);

	// Clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Integer square root, bit by bit.
	function automatic logic [63:0] root_floor(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Round Q32.32 to Q16.16, half toward plus infinity.
	function automatic longint round_q16(input longint v);
		longint w;
		w = v + 32768;
		if (w >= 0) return longint'(64'(w) >> 16);
		return -longint'((64'(-w) + 64'd65535) >> 16);
	endfunction

	function automatic longint clamp_word(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Scale a vector to unit length in Q16.16; returns 0 on a zero vector.
	function automatic bit unit_vector(input longint v[3], output longint r[3]);
		logic [63:0] mag[3];
		logic [63:0] top;
		logic [63:0] sum;
		logic [63:0] len;
		top = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
			if (mag[i] > top) top = mag[i];
		end
		if (top == 0) return 1'b0;
		while (top >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
			top = top >> 1;
		end
		while (top < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
			top = top << 1;
		end
		for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
		len = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			r[i] = longint'(((mag[i] << 16) + (len >> 1)) / len);
			if (v[i] < 0) r[i] = -r[i];
		end
		return 1'b1;
	endfunction

	// Build the four expected columns of the view matrix for one request.
	task automatic predict_view_matrix(input req_t r);
		longint eye[3], up[3], dir[3], zax[3], crs[3], xax[3], yax[3], tr[3];
		longint mat[16];
		bit ok;
		rsp_t col;
		eye = '{r.eye_x, r.eye_y, r.eye_z};
		up = '{r.upward_x, r.upward_y, r.upward_z};
		dir[0] = eye[0] - longint'(r.look_x);
		dir[1] = eye[1] - longint'(r.look_y);
		dir[2] = eye[2] - longint'(r.look_z);
		for (int i = 0; i < 16; i++) mat[i] = 0;
		ok = unit_vector(dir, zax);
		if (ok) begin
			crs[0] = up[1] * zax[2] - up[2] * zax[1];
			crs[1] = up[2] * zax[0] - up[0] * zax[2];
			crs[2] = up[0] * zax[1] - up[1] * zax[0];
			ok = unit_vector(crs, xax);
		end
		if (ok) begin
			yax[0] = round_q16(zax[1] * xax[2] - zax[2] * xax[1]);
			yax[1] = round_q16(zax[2] * xax[0] - zax[0] * xax[2]);
			yax[2] = round_q16(zax[0] * xax[1] - zax[1] * xax[0]);
			tr[0] = clamp_word(round_q16(-(eye[0]*xax[0] + eye[1]*xax[1] + eye[2]*xax[2])));
			tr[1] = clamp_word(round_q16(-(eye[0]*yax[0] + eye[1]*yax[1] + eye[2]*yax[2])));
			tr[2] = clamp_word(round_q16(-(eye[0]*zax[0] + eye[1]*zax[1] + eye[2]*zax[2])));
			for (int i = 0; i < 3; i++) begin
				mat[4*i] = xax[i];
				mat[4*i+1] = yax[i];
				mat[4*i+2] = zax[i];
				mat[12+i] = tr[i];
			end
			mat[15] = Q_ONE;
		end
		for (int c = 0; c < 4; c++) begin
			col.column_index = 2'(c);
			col.row0_value = word_t'(mat[4*c]);
			col.row1_value = word_t'(mat[4*c+1]);
			col.row2_value = word_t'(mat[4*c+2]);
			col.row3_value = word_t'(mat[4*c+3]);
			col.last_column = (c == COL_LAST);
			col.degenerate = !ok;
			expected_columns.push_back(col);
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("column mismatch at cycle %0d: %s got %0d expected %0d",
			cycle_count, what, got, want);
		mismatch_count++;
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return word_t'($urandom_range(0, 2000)) - 1000;
			3: return word_t'($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Driver: issues requests at the falling edge.
	always @(negedge clk) begin
		if (took_req) begin
			void'(pending_reqs.pop_front());
		end
		if (!arst_n || hold_send || pending_reqs.size() == 0 ||
				($urandom_range(0, 99) < send_idle_pct)) begin
			start <= 1'b0;
		end else begin
			start <= 1'b1;
			req <= pending_reqs[0];
		end
	end

	// Acceptance of requests feeds the prediction and retires the request.
	always @(posedge clk) begin
		took_req <= arst_n && start && !busy;
		if (arst_n && start && !busy) predict_view_matrix(req);
	end

	// Monitor: compares each column against the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && strobe) begin
			if (expected_columns.size() == 0) begin
				report_mismatch("unexpected column", rsp.column_index, -1);
			end else begin
				want = expected_columns.pop_front();
				if (rsp.column_index !== want.column_index)
					report_mismatch("column_index", rsp.column_index, want.column_index);
				if (rsp.row0_value !== want.row0_value)
					report_mismatch("row0_value", rsp.row0_value, want.row0_value);
				if (rsp.row1_value !== want.row1_value)
					report_mismatch("row1_value", rsp.row1_value, want.row1_value);
				if (rsp.row2_value !== want.row2_value)
					report_mismatch("row2_value", rsp.row2_value, want.row2_value);
				if (rsp.row3_value !== want.row3_value)
					report_mismatch("row3_value", rsp.row3_value, want.row3_value);
				if (rsp.last_column !== want.last_column)
					report_mismatch("last_column", rsp.last_column, want.last_column);
				if (rsp.degenerate !== want.degenerate)
					report_mismatch("degenerate", rsp.degenerate, want.degenerate);
			end
		end
	end

	// Timeout: guards a run of about 300 items against a hang.
	always @(posedge clk) begin
		if (cycle_count > 600000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic queue_camera(input word_t ex, ey, ez, lx, ly, lz, ux, uy, uz);
		req_t r;
		r = '{ex, ey, ez, lx, ly, lz, ux, uy, uz};
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || start) @(posedge clk);
		while (expected_columns.size() != 0) @(posedge clk);
	endtask

	// Stimulus sequence.
	initial begin
		int phase_items;
		word_t lx, ly, lz;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		mismatch_count = 0;
		cycle_count = 0;
		hold_send = 1'b0;
		send_idle_pct = 26;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: identity camera, zero view direction, up parallel, zero up, extremes.
		queue_camera(0, 0, 32'sd65536 * 5, 0, 0, 0, 0, 32'sd65536, 0);
		queue_camera(32'sd1000, 32'sd2000, 32'sd3000, 32'sd1000, 32'sd2000, 32'sd3000,
			0, 32'sd65536, 0);
		queue_camera(0, 0, 32'sd65536, 0, 0, 0, 0, 0, 32'sd65536);
		queue_camera(32'sd65536, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_camera(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 32'sh80000000);
		queue_camera(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
		queue_camera(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		queue_camera(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1, 0, 0, 1, 1, 1);
		queue_camera(1, 0, 0, 0, 0, 0, 0, 1, 0);
		queue_camera(-1, -1, -1, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
		queue_camera(32'sh12345678, -32'sh01234567, 32'sh00100000, 0, 0, 0,
			-1, -1, -1);
		queue_camera(0, 0, 0, 0, 0, 0, 0, 0, 0);
		wait_drained();

		// Pause until every column has come, then three random phases.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 80 : 0;
			phase_items = (phase == 2) ? 100 : 90;
			for (int n = 0; n < phase_items; n++) begin
				word_t ex, ey, ez;
				ex = rand_word();
				ey = rand_word();
				ez = rand_word();
				if ($urandom_range(0, 19) == 0) begin
					lx = ex; ly = ey; lz = ez;
				end else begin
					lx = rand_word(); ly = rand_word(); lz = rand_word();
				end
				if ($urandom_range(0, 19) == 0)
					queue_camera(ex, ey, ez, lx, ly, lz, ex - lx, ey - ly, ez - lz);
				else
					queue_camera(ex, ey, ez, lx, ly, lz, rand_word(), rand_word(),
						rand_word());
			end
			wait_drained();
		end
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_columns.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
